### rtl/svf_pkg.sv
// ----------------------------------------------------------------------------
// svf_pkg: shared types and constants for the multimode state-variable filter
// Holds the mode codes, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package svf_pkg;

	localparam int GW = 24;          // coefficient width, Q4.20
	localparam int KW = 16;          // damping width, Q2.14
	localparam int GFRAC = 20;
	localparam int KFRAC = 14;
	localparam int DENW = 50;        // 1 + g*(g+k) in Q.20

	localparam logic [0:0] REG_MODE    = 1'b0;
	localparam logic [0:0] REG_DAMPING = 1'b1;

	typedef enum logic [2:0] {
		MODE_LP12    = 3'd0,
		MODE_LP24    = 3'd1,
		MODE_HP12    = 3'd2,
		MODE_HP24    = 3'd3,
		MODE_BP12    = 3'd4,
		MODE_BP24    = 3'd5,
		MODE_NOTCH   = 3'd6,
		MODE_ALLPASS = 3'd7
	} mode_t;

	typedef enum logic [2:0] {
		TAP_LP, TAP_HP, TAP_BP, TAP_NOTCH, TAP_AP
	} tap_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DEN,      // g*(g+k)
		ST_GX,       // g*(x-s2)
		ST_DIV,      // num / den, one quotient bit a cycle
		ST_GV1,      // g*v1
		ST_KV1,      // k*v1
		ST_UPD,      // integrators and tap
		ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctl_t;

endpackage

### rtl/svf_div.sv
// ----------------------------------------------------------------------------
// svf_div: restoring divider, trunc(|a| * 2^20 / den), one bit per cycle
// Unsigned magnitude in and out; sign is handled by the caller.
// ----------------------------------------------------------------------------
module svf_div
	import svf_pkg::*;
#(
	parameter int NW = 64,
	parameter int QW = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [NW-1:0]   numer,
	input  logic [DENW-1:0] denom,
	output div_ctl_t        ctl,
	output logic [QW-1:0]   quot
);
	localparam int TW = NW + GFRAC;
	localparam int CW = $clog2(TW + 1);
	localparam int RW = DENW + 1;

	logic [TW-1:0]   dvd_q;
	logic [RW-1:0]   rem_q;
	logic [CW-1:0]   cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [RW-1:0]   trial;
	logic [RW:0]     diff;

	assign trial = {rem_q[RW-2:0], dvd_q[TW-1]};
	assign diff  = {1'b0, trial} - {2'b00, denom};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(TW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift into the low end of the dividend register
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {numer, {GFRAC{1'b0}}};
			rem_q <= '0;
		end else if (busy_q) begin
			if (!diff[RW]) begin
				rem_q <= diff[RW-1:0];
				dvd_q <= {dvd_q[TW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				dvd_q <= {dvd_q[TW-2:0], 1'b0};
			end
		end
	end

	assign ctl.start = start;
	assign ctl.busy  = busy_q;
	assign ctl.done  = done_q;
	// quotient is bounded by numer; any overflow into the upper bits saturates to all ones
	assign quot = (|dvd_q[TW-1:QW]) ? {QW{1'b1}} : dvd_q[QW-1:0];

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without busy");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider restarted while busy");
	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider busy after done");
endmodule

### rtl/state_variable_filter_multimode.sv
// ----------------------------------------------------------------------------
// state_variable_filter_multimode: trapezoidal SVF, 12/24 dB, five responses
// One shared multiplier and a bit-serial divider under a small sequencer.
// ----------------------------------------------------------------------------
//  channel | signals                               | dir
//  in      | in_valid, in_stall, sample_in,        | in  (in_stall out)
//          | coeff_g, clear_state                  |
//  out     | out_valid, out_stall, sample_out,     | out (out_stall in)
//          | clipped                               |
//  cfg     | cfg_we, cfg_index, cfg_wdata          | in
//
// Each filter stage steps through ST_DEN, ST_GX, ST_DIV, ST_GV1, ST_KV1 and
// ST_UPD; 24 dB modes run the stage again on its own tap, and ST_OUT then
// registers the result beat. The divider takes one quotient bit per cycle over
// STATE_WIDTH+26 bits (58 by default).
// Reset at once clears the integrators and resets the control registers only.
// in_stall is high from acceptance until the result beat leaves; the result
// holds in its output register while out_stall is high.
module state_variable_filter_multimode
	import svf_pkg::*;
#(
	parameter int SAMPLE_WIDTH = 24,
	parameter int STATE_WIDTH  = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	input  logic        [GW-1:0]           coeff_g,
	input  logic                           clear_state,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [SAMPLE_WIDTH-1:0] sample_out,
	output logic                           clipped,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic        [KW-1:0]           cfg_wdata
);
	localparam int SW = STATE_WIDTH;
	localparam int WW = SW + 6;                // headroom for g*(x-s2), up to 16x
	localparam int PW = WW + GW + 1;           // product width
	localparam logic signed [WW-1:0] SMAX = WW'((64'sd1 <<< (SW - 1)) - 1);
	localparam logic signed [WW-1:0] SMIN = -SMAX - 1;

	function automatic logic signed [WW-1:0] sat_s(input logic signed [WW-1:0] v);
		if (v > SMAX) return SMAX;
		if (v < SMIN) return SMIN;
		return v;
	endfunction

	state_t state_q, state_d;
	mode_t  mode_q;
	logic [KW-1:0] damp_q;

	logic signed [SW-1:0] s1_q [2];
	logic signed [SW-1:0] s2_q [2];

	logic              stage_q;
	logic              cascade_q;
	tap_t              tap_q;
	logic [GW-1:0]     g_q;
	logic signed [WW-1:0] x_q;
	logic [DENW-1:0]   den_q;
	logic signed [WW-1:0] num_q, v1_q, v2_q, kv1_q;
	logic              ovalid_q;
	logic signed [SAMPLE_WIDTH-1:0] oy_q;
	logic              oclip_q;

	// shared multiplier: unsigned coefficient times signed magnitude
	logic [GW:0]       m_c;
	logic signed [WW-1:0] m_a;
	logic [WW-1:0]     m_mag;
	logic [PW-1:0]     m_p;
	logic [4:0]        m_sh;
	logic [PW-1:0]     m_shifted;
	logic signed [WW-1:0] m_res;

	logic              div_start;
	div_ctl_t          div_ctl;
	logic [WW-1:0]     div_q;
	logic [WW-1:0]     num_mag;
	logic              dstarted_q;

	logic              take;
	logic signed [SW-1:0] s1c, s2c;

	assign take     = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE) || ovalid_q;
	assign s1c      = s1_q[stage_q];
	assign s2c      = s2_q[stage_q];

	always_comb begin
		m_c = '0;
		m_a = '0;
		m_sh = 5'(GFRAC);
		unique case (state_q)
			ST_DEN: begin
				m_c = {1'b0, g_q};
				m_a = WW'(g_q) + (WW'(damp_q) << (GFRAC - KFRAC));
			end
			ST_GX:  begin m_c = {1'b0, g_q}; m_a = x_q - WW'(s2c); end
			ST_GV1: begin m_c = {1'b0, g_q}; m_a = v1_q; end
			ST_KV1: begin
				m_c = (GW+1)'(damp_q);
				m_a = v1_q;
				m_sh = (tap_q == TAP_AP) ? 5'(KFRAC - 1) : 5'(KFRAC);
			end
			default: ;
		endcase
		m_mag = m_a[WW-1] ? WW'(-m_a) : WW'(m_a);
		m_p = PW'(m_c) * PW'(m_mag);
		m_shifted = m_p >> m_sh;
		m_res = m_a[WW-1] ? -WW'(m_shifted) : WW'(m_shifted);
	end

	assign num_mag = num_q[WW-1] ? WW'(-num_q) : WW'(num_q);

	svf_div #(.NW(WW), .QW(WW)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.numer (num_mag),
		.denom (den_q),
		.ctl   (div_ctl),
		.quot  (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		unique case (state_q)
			ST_IDLE: if (take) state_d = ST_DEN;
			ST_DEN:  state_d = ST_GX;
			ST_GX:   begin state_d = ST_DIV; end
			ST_DIV:  begin
				div_start = !div_ctl.busy && !div_ctl.done && !dstarted_q;
				if (div_ctl.done) state_d = ST_GV1;
			end
			ST_GV1:  state_d = ST_KV1;
			ST_KV1:  state_d = ST_UPD;
			ST_UPD:  state_d = (cascade_q && !stage_q) ? ST_DEN : ST_OUT;
			ST_OUT:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dstarted_q <= 1'b0;
		else if (state_q != ST_DIV) dstarted_q <= 1'b0;
		else if (div_start) dstarted_q <= 1'b1;
	end

	logic signed [WW-1:0] tap_y, v1s, y_sat_st;
	always_comb begin
		unique case (tap_q)
			TAP_LP:  tap_y = v2_q;
			TAP_HP:  tap_y = x_q - kv1_q - v2_q;
			TAP_BP:  tap_y = v1_q;
			default: tap_y = x_q - kv1_q;
		endcase
		y_sat_st = sat_s(tap_y);
		v1s = num_q[WW-1] ? -WW'(div_q) : WW'(div_q);
	end

	localparam logic signed [WW-1:0] OMAX = WW'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1);
	localparam logic signed [WW-1:0] OMIN = -OMAX - 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_LP12;
			damp_q   <= KW'(32768);
			ovalid_q <= 1'b0;
			for (int i = 0; i < 2; i++) begin
				s1_q[i] <= '0;
				s2_q[i] <= '0;
			end
			stage_q   <= 1'b0;
			cascade_q <= 1'b0;
			tap_q     <= TAP_LP;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_MODE) mode_q <= mode_t'(cfg_wdata[2:0]);
				else                       damp_q <= cfg_wdata;
			end
			if (ovalid_q && !out_stall) ovalid_q <= 1'b0;
			if (take) begin
				stage_q <= 1'b0;
				if (clear_state) begin
					for (int i = 0; i < 2; i++) begin
						s1_q[i] <= '0;
						s2_q[i] <= '0;
					end
				end
				unique case (mode_q)
					MODE_LP12:  begin tap_q <= TAP_LP; cascade_q <= 1'b0; end
					MODE_LP24:  begin tap_q <= TAP_LP; cascade_q <= 1'b1; end
					MODE_HP12:  begin tap_q <= TAP_HP; cascade_q <= 1'b0; end
					MODE_HP24:  begin tap_q <= TAP_HP; cascade_q <= 1'b1; end
					MODE_BP12:  begin tap_q <= TAP_BP; cascade_q <= 1'b0; end
					MODE_BP24:  begin tap_q <= TAP_BP; cascade_q <= 1'b1; end
					MODE_NOTCH: begin tap_q <= TAP_NOTCH; cascade_q <= 1'b0; end
					default:    begin tap_q <= TAP_AP; cascade_q <= 1'b0; end
				endcase
			end
			if (state_q == ST_UPD) begin
				s1_q[stage_q] <= SW'(sat_s((v1_q <<< 1) - WW'(s1c)));
				s2_q[stage_q] <= SW'(sat_s((v2_q <<< 1) - WW'(s2c)));
				if (cascade_q && !stage_q) stage_q <= 1'b1;
			end
			if (state_q == ST_OUT) ovalid_q <= 1'b1;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (take) begin
			g_q <= coeff_g;
			x_q <= WW'(sample_in);
		end
		unique case (state_q)
			ST_DEN: den_q <= DENW'(1 << GFRAC) + DENW'(m_shifted);
			ST_GX:  num_q <= WW'(s1c) + m_res;
			ST_DIV: if (div_ctl.done) v1_q <= sat_s(v1s);
			ST_GV1: v2_q <= sat_s(WW'(s2c) + m_res);
			ST_KV1: kv1_q <= m_res;
			ST_UPD: x_q <= y_sat_st;  // tap feeds the cascade stage or the output
			ST_OUT: begin
				if (x_q > OMAX)      begin oy_q <= SAMPLE_WIDTH'(OMAX); oclip_q <= 1'b1; end
				else if (x_q < OMIN) begin oy_q <= SAMPLE_WIDTH'(OMIN); oclip_q <= 1'b1; end
				else                 begin oy_q <= SAMPLE_WIDTH'(x_q);  oclip_q <= 1'b0; end
			end
			default: ;
		endcase
	end

	assign out_valid  = ovalid_q;
	assign sample_out = oy_q;
	assign clipped    = oclip_q;

	a_busy_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall)
		else $error("input taken mid-computation");
	a_out_after_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovalid_q) |-> $past(state_q == ST_OUT))
		else $error("result beat without completion");
	a_cascade_stage: assert property (@(posedge clk) disable iff (!arst_n)
		stage_q |-> cascade_q)
		else $error("second stage without cascade mode");
endmodule

### test/state_variable_filter_multimode_tb.sv
// ----------------------------------------------------------------------------
// state_variable_filter_multimode_tb: self-checking bench for the SVF core
// Drives samples with random gaps and output stalls, runs each filter mode,
// then random modes over several damping settings, predicts each result with
// a bit-exact fixed-point filter model and checks every output beat against it.
// ----------------------------------------------------------------------------
module state_variable_filter_multimode_tb;
	import svf_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SW = 24;
	localparam int STW = 32;
	localparam longint CYCLE_LIMIT = 3000000;

	typedef struct {
		logic [SW-1:0] y;
		logic          clip;
	} filt_out_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic signed [SW-1:0] sample_in;
	logic        [GW-1:0] coeff_g;
	logic                 clear_state;
	logic                 out_valid;
	logic                 out_stall;
	logic signed [SW-1:0] sample_out;
	logic                 clipped;
	logic                 cfg_we;
	logic                 cfg_index;
	logic        [KW-1:0] cfg_wdata;

	// filter model state
	longint          integ1 [2];
	longint          integ2 [2];
	mode_t           cur_mode;
	longint unsigned cur_damp;
	filt_out_t       filt_q [$];

	int     mismatches = 0;
	longint cycles = 0;
	int     rx_wait;
	int     rx_hold;
	bit     rx_idle_en;
	bit     tx_idle_en;

	state_variable_filter_multimode dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic longint clamp_w(longint v, int w, inout bit hit);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (w - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			hit = 1'b1;
			return hi;
		end
		if (v < lo) begin
			hit = 1'b1;
			return lo;
		end
		return v;
	endfunction

	function automatic longint clamp_state(longint v);
		bit unused;
		unused = 1'b0;
		return clamp_w(v, STW, unused);
	endfunction

	// product truncated toward zero
	function automatic longint scale_trunc(longint unsigned c, longint a, int s);
		longint unsigned u;
		longint unsigned mask;
		longint unsigned p;
		u = (a < 0) ? longint'(-a) : a;
		mask = (64'd1 << s) - 1;
		p = c * (u >> s) + ((c * (u & mask)) >> s);
		return (a < 0) ? -longint'(p) : longint'(p);
	endfunction

	function automatic longint quot_q20(longint a, longint unsigned den);
		longint unsigned u;
		longint unsigned q;
		u = (a < 0) ? longint'(-a) : a;
		q = ((u / den) << 20) + (((u % den) << 20) / den);
		return (a < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint filter_stage(int idx, longint x, longint unsigned g,
			longint unsigned k, tap_t tap);
		longint          s1;
		longint          s2;
		longint unsigned den;
		longint          v1;
		longint          v2;
		longint          y;
		s1 = integ1[idx];
		s2 = integ2[idx];
		den = (64'd1 << 20) + ((g * (g + (k << 6))) >> 20);
		v1 = clamp_state(quot_q20(s1 + scale_trunc(g, x - s2, 20), den));
		v2 = clamp_state(s2 + scale_trunc(g, v1, 20));
		integ1[idx] = clamp_state(2 * v1 - s1);
		integ2[idx] = clamp_state(2 * v2 - s2);
		case (tap)
			TAP_LP:    y = v2;
			TAP_HP:    y = x - scale_trunc(k, v1, 14) - v2;
			TAP_BP:    y = v1;
			TAP_NOTCH: y = x - scale_trunc(k, v1, 14);
			default:   y = x - scale_trunc(k, v1, 13);
		endcase
		return clamp_state(y);
	endfunction

	function automatic filt_out_t predict_sample(logic signed [SW-1:0] xs,
			logic [GW-1:0] g, logic clr);
		tap_t      tap;
		bit        cascade;
		bit        hit;
		longint    y;
		filt_out_t r;
		hit = 1'b0;
		if (clr) begin
			integ1[0] = 0;
			integ1[1] = 0;
			integ2[0] = 0;
			integ2[1] = 0;
		end
		cascade = (cur_mode == MODE_LP24) || (cur_mode == MODE_HP24) ||
			(cur_mode == MODE_BP24);
		case (cur_mode)
			MODE_LP12, MODE_LP24: tap = TAP_LP;
			MODE_HP12, MODE_HP24: tap = TAP_HP;
			MODE_BP12, MODE_BP24: tap = TAP_BP;
			MODE_NOTCH:           tap = TAP_NOTCH;
			default:              tap = TAP_AP;
		endcase
		y = filter_stage(0, longint'(xs), g, cur_damp, tap);
		if (cascade)
			y = filter_stage(1, y, g, cur_damp, tap);
		y = clamp_w(y, SW, hit);
		r.y = y[SW-1:0];
		r.clip = hit;
		return r;
	endfunction

	// send one sample beat, predict on acceptance
	task automatic send_sample(logic signed [SW-1:0] xs, logic [GW-1:0] g, logic clr);
		int gap;
		gap = tx_idle_en ? $urandom_range(0, 17) : 0;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_in = xs;
		coeff_g = g;
		clear_state = clr;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		filt_q = {filt_q, predict_sample(xs, g, clr)};
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (filt_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [KW-1:0] val);
		drain();
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		if (idx == REG_MODE)
			cur_mode = mode_t'(val[2:0]);
		else
			cur_damp = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic logic [GW-1:0] pick_coeff();
		case ($urandom_range(0, 9))
			0:       return GW'($urandom);
			1:       return GW'($urandom_range(0, 64));
			2:       return {GW{1'b1}};
			default: return GW'($urandom_range(0, 24'h100000));
		endcase
	endfunction

	function automatic logic signed [SW-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0:       return {1'b0, {(SW-1){1'b1}}};
			1:       return {1'b1, {(SW-1){1'b0}}};
			default: return SW'($urandom);
		endcase
	endfunction

	task automatic test_directed();
		mode_t m;
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		// reset defaults: lowpass 12 dB, k = 2.0
		send_sample(24'sh7FFFFF, 24'h100000, 1'b0);
		send_sample(24'sh800000, 24'hFFFFFF, 1'b0);
		send_sample(24'sh000000, 24'h000000, 1'b0);
		send_sample(24'sh400000, 24'h080000, 1'b1);
		// every mode, full-scale steps
		m = m.first();
		do begin
			write_reg(REG_MODE, KW'(m));
			send_sample(24'sh7FFFFF, 24'hFFFFFF, 1'b1);
			send_sample(24'sh800000, 24'h200000, 1'b0);
			m = m.next();
		end while (m != m.first());
		// damping above 2.0 and zero damping
		write_reg(REG_DAMPING, 16'hFFFF);
		send_sample(24'sh7FFFFF, 24'h0FFFFF, 1'b0);
		write_reg(REG_DAMPING, 16'h0000);
		send_sample(24'sh800000, 24'h0FFFFF, 1'b0);
		send_sample(24'sh123456, 24'h000001, 1'b1);
	endtask

	task automatic test_random_modes(int n_items);
		logic [KW-1:0] damps [5];
		int            per;
		damps[0] = 16'h0000;
		damps[1] = 16'h8000;
		damps[2] = 16'hFFFF;
		damps[3] = 16'h0001;
		damps[4] = 16'h0000;
		per = n_items / 16;
		for (int s = 0; s < 16; s++) begin
			damps[4] = KW'($urandom);
			write_reg(REG_MODE, KW'($urandom_range(0, 7)));
			write_reg(REG_DAMPING, damps[$urandom_range(0, 4)]);
			tx_idle_en = (s % 4) != 1;
			rx_idle_en = (s % 4) != 2;
			for (int i = 0; i < per; i++)
				send_sample(pick_sample(), pick_coeff(), $urandom_range(0, 19) == 0);
		end
	endtask

	task automatic test_backpressure();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		write_reg(REG_MODE, KW'(MODE_BP24));
		rx_hold = 2000;
		for (int i = 0; i < 20; i++)
			send_sample(pick_sample(), pick_coeff(), 1'b0);
		// hold off until every result is back, then resume
		drain();
		for (int i = 0; i < 20; i++)
			send_sample(pick_sample(), pick_coeff(), 1'b0);
	endtask

	// receiver stall
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			out_stall = 1'b1;
			rx_hold = rx_hold - 1;
		end else if (rx_wait > 0) begin
			out_stall = 1'b1;
			rx_wait = rx_wait - 1;
		end else begin
			out_stall = 1'b0;
		end
	end

	// check each result beat
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (filt_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: sample_out=%h clipped=%b", sample_out, clipped);
			end else begin
				filt_out_t e;
				e = filt_q.pop_front();
				if (sample_out !== e.y || clipped !== e.clip) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: sample_out exp %h got %h, clipped exp %b got %b",
							e.y, sample_out, e.clip, clipped);
				end
			end
			rx_wait = rx_idle_en ? $urandom_range(0, 17) : 0;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample_in = '0;
		coeff_g = '0;
		clear_state = 1'b0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_MODE;
		cfg_wdata = '0;
		rx_wait = 0;
		rx_hold = 0;
		rx_idle_en = 1'b0;
		tx_idle_en = 1'b0;
		integ1[0] = 0;
		integ1[1] = 0;
		integ2[0] = 0;
		integ2[1] = 0;
		cur_mode = MODE_LP12;
		cur_damp = 32768;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_backpressure();
		test_random_modes(1400);

		drain();
		repeat (400) @(negedge clk);
		if (mismatches == 0 && filt_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

### sim.f
rtl/svf_pkg.sv
rtl/svf_div.sv
rtl/state_variable_filter_multimode.sv
test/state_variable_filter_multimode_tb.sv
